FILE: sv/srs_pkg.sv
// Shared types and constants for the systematic resampler.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package srs_pkg;

   // Default size of the particle set.
   localparam int MAX_PARTICLES_DEF = 64;

   // Field widths of the channels.
   localparam int WEIGHT_W = 16;
   localparam int OFFSET_W = 16;
   localparam int INDEX_W  = 6;

   // Fraction bits of the weights and of the offset.
   localparam int FRAC_W = 16;

   // Running weight total: 64 weights of 16 bits always fit in 22 bits.
   localparam int TOTAL_W = 22;

   // Cumulative weight times the set size (set size is at most 7 bits).
   localparam int CUMN_W = TOTAL_W + INDEX_W + 1;

   // Width of both sides of the threshold compare.
   localparam int CMP_W = CUMN_W + FRAC_W;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SETUP,
      ST_READ,
      ST_ACCUM,
      ST_TEST,
      ST_IDENT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;    // input channel open for items
      logic start;   // latch set size and initial threshold
      logic accum;   // add the next weight into the cumulative sum
      logic emit;    // load the output register with one index
      logic ident;   // emit the slot number rather than the particle
      logic finish;  // clear the set after its final index
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_taken;  // the item closing the set is accepted
      logic total_zero;  // the set's weights sum to zero
      logic above;       // cumulative weight exceeds the current threshold
      logic out_free;    // the output register can take an item
      logic final_slot;  // the current slot is the last of the run
   } status_type;

endpackage

`default_nettype wire

FILE: sv/srs_req_if.sv
// Input channel of the resampler: one weight per item.
// Depends on srs_pkg for the field widths.
`default_nettype none

interface srs_req_if;
   logic                          valid;
   logic                          ready;
   logic [srs_pkg::WEIGHT_W-1:0]  weight;
   logic                          is_last;
   logic [srs_pkg::OFFSET_W-1:0]  offset_fraction;

   modport source (output valid, output weight, output is_last, output offset_fraction,
                   input ready);
   modport sink (input valid, input weight, input is_last, input offset_fraction,
                 output ready);
endinterface

`default_nettype wire

FILE: sv/srs_rsp_if.sv
// Result channel of the resampler: one survivor index per item.
// Depends on srs_pkg for the field widths.
`default_nettype none

interface srs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [srs_pkg::INDEX_W-1:0]  survivor_index;
   logic                         last_index;
   logic                         total_zero;

   modport source (output valid, output survivor_index, output last_index,
                   output total_zero, input ready);
   modport sink (input valid, input survivor_index, input last_index,
                 input total_zero, output ready);
endinterface

`default_nettype wire

FILE: sv/srs_controller.sv
// Sequencer of the resampler: loading, set-up, the walk over the store and emission.
// Depends on srs_pkg for the state, command and status types.
`default_nettype none

module srs_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire srs_pkg::status_type status,
   output srs_pkg::cmd_type         cmd
);

   srs_pkg::state_type state_ff;
   srs_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srs_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srs_pkg::ST_LOAD: begin
            if (status.last_taken) begin
               state_in = srs_pkg::ST_SETUP;
            end
         end
         srs_pkg::ST_SETUP: begin
            state_in = status.total_zero ? srs_pkg::ST_IDENT : srs_pkg::ST_READ;
         end
         srs_pkg::ST_READ: begin
            state_in = srs_pkg::ST_ACCUM;
         end
         srs_pkg::ST_ACCUM: begin
            state_in = srs_pkg::ST_TEST;
         end
         srs_pkg::ST_TEST: begin
            // Stay while thresholds are crossed; move on to the next particle otherwise.
            if (status.above) begin
               if (status.out_free && status.final_slot) begin
                  state_in = srs_pkg::ST_LOAD;
               end
            end else begin
               state_in = srs_pkg::ST_ACCUM;
            end
         end
         srs_pkg::ST_IDENT: begin
            if (status.out_free && status.final_slot) begin
               state_in = srs_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = srs_pkg::ST_LOAD;
         end
      endcase
   end

   // Commands.
   always_comb begin
      cmd = '0;
      case (state_ff)
         srs_pkg::ST_LOAD: begin
            cmd.take = 1'b1;
         end
         srs_pkg::ST_SETUP: begin
            cmd.start = 1'b1;
         end
         srs_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
         end
         srs_pkg::ST_TEST: begin
            cmd.emit   = status.above && status.out_free;
            cmd.finish = status.above && status.out_free && status.final_slot;
         end
         srs_pkg::ST_IDENT: begin
            cmd.ident  = 1'b1;
            cmd.emit   = status.out_free;
            cmd.finish = status.out_free && status.final_slot;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/srs_datapath.sv
// Datapath of the resampler: weight store, running sums, threshold compare, output register.
// Depends on srs_pkg for widths and the command and status types.
`default_nettype none

module srs_datapath #(
   parameter int MAX_PARTICLES = srs_pkg::MAX_PARTICLES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire srs_pkg::cmd_type              cmd,
   output srs_pkg::status_type                status,
   input  wire logic                          req_valid,
   input  wire logic [srs_pkg::WEIGHT_W-1:0]  req_weight,
   input  wire logic                          req_is_last,
   input  wire logic [srs_pkg::OFFSET_W-1:0]  req_offset_fraction,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [srs_pkg::INDEX_W-1:0]        rsp_survivor_index,
   output logic                               rsp_last_index,
   output logic                               rsp_total_zero
);

   localparam int IW = $clog2(MAX_PARTICLES);
   localparam int CW = $clog2(MAX_PARTICLES + 1);

   logic [srs_pkg::WEIGHT_W-1:0] weight_mem [MAX_PARTICLES];

   logic [CW-1:0]                count_ff;
   logic [srs_pkg::TOTAL_W-1:0]  total_ff;
   logic [srs_pkg::OFFSET_W-1:0] offset_ff;
   logic [CW-1:0]                n_ff;
   logic [CW-1:0]                rd_ptr_ff;
   logic [IW-1:0]                cur_ff;
   logic [srs_pkg::WEIGHT_W-1:0] rd_data_ff;
   logic [srs_pkg::CUMN_W-1:0]   cum_n_ff;
   logic [srs_pkg::CMP_W-1:0]    thresh_ff;
   logic [CW-1:0]                slot_ff;

   logic                         out_valid_ff;
   logic [srs_pkg::INDEX_W-1:0]  out_index_ff;
   logic                         out_last_ff;
   logic                         out_zero_ff;

   logic                         req_fire;
   logic                         store_room;
   logic [srs_pkg::CMP_W-1:0]    cum_scaled;
   logic [IW-1:0]                emit_index;

   assign req_fire   = req_valid && cmd.take;
   assign store_room = (count_ff != CW'(MAX_PARTICLES));
   assign cum_scaled = {cum_n_ff, srs_pkg::FRAC_W'(0)};
   assign emit_index = cmd.ident ? slot_ff[IW-1:0] : cur_ff;

   // Status back to the sequencer.
   always_comb begin
      status.last_taken = req_fire && req_is_last;
      status.total_zero = (total_ff == '0);
      status.above      = (cum_scaled > thresh_ff);
      status.out_free   = !out_valid_ff || rsp_ready;
      status.final_slot = (slot_ff == n_ff - CW'(1));
   end

   // Weight store: written while loading, read one entry per particle during the walk.
   always_ff @(posedge clock) begin
      if (req_fire && store_room) begin
         weight_mem[count_ff[IW-1:0]] <= req_weight;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= weight_mem[rd_ptr_ff[IW-1:0]];
   end

   // Fill count and running total; a full store drops further weights.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
      end else if (cmd.finish) begin
         count_ff <= '0;
         total_ff <= '0;
      end else if (req_fire && store_room) begin
         count_ff <= count_ff + CW'(1);
         total_ff <= total_ff + srs_pkg::TOTAL_W'(req_weight);
      end
   end

   // The offset is taken from the item that closes the set.
   always_ff @(posedge clock) begin
      if (req_fire && req_is_last) begin
         offset_ff <= req_offset_fraction;
      end
   end

   // Walk over the store: set size, read pointer and cumulative weight times n.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         n_ff      <= count_ff;
         rd_ptr_ff <= '0;
         cum_n_ff  <= '0;
      end else if (cmd.accum) begin
         cum_n_ff  <= cum_n_ff + srs_pkg::CUMN_W'(rd_data_ff) * srs_pkg::CUMN_W'(n_ff);
         cur_ff    <= rd_ptr_ff[IW-1:0];
         rd_ptr_ff <= rd_ptr_ff + CW'(1);
      end
   end

   // Threshold (k + u) * T scaled by 65536, stepped by T * 65536 for each index.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         slot_ff   <= '0;
         thresh_ff <= srs_pkg::CMP_W'(offset_ff) * srs_pkg::CMP_W'(total_ff);
      end else if (cmd.emit) begin
         slot_ff   <= slot_ff + CW'(1);
         thresh_ff <= thresh_ff + (srs_pkg::CMP_W'(total_ff) << srs_pkg::FRAC_W);
      end
   end

   // Output register: holds one item until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_index_ff <= srs_pkg::INDEX_W'(emit_index);
         out_last_ff  <= status.final_slot;
         out_zero_ff  <= cmd.ident;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_survivor_index = out_index_ff;
   assign rsp_last_index     = out_last_ff;
   assign rsp_total_zero     = out_zero_ff;

endmodule

`default_nettype wire

FILE: sv/systematic_resampler.sv
// Systematic (low-variance) resampler for a particle filter.
// Depends on srs_pkg, srs_req_if, srs_rsp_if, srs_controller and srs_datapath.
//
// Usage: weights enter on req_chan, one item per cycle while the block is
// loading. The item with is_last set closes the set and carries the random
// offset; the block then stops taking items and sends the survivor indices of
// the set, one item each, on rsp_chan, the last of them with last_index set.
// Sequence: after the closing item come the set-up state and the store read
// state; each particle then passes an accumulate state and a test state, and
// the walk stays in the test state while the particle contributes indices.
// A set whose weights sum to zero yields the indices 0 .. n-1 at one per
// cycle, while the receiver keeps up, after the set-up state.
// Reset empties the set and the output register; the store itself is not
// cleared. A stalled receiver holds the pending item in the output register
// and the walk waits until it is taken; loading resumes after the last index
// has been handed to the output register.
`default_nettype none

module systematic_resampler #(
   parameter int MAX_PARTICLES = srs_pkg::MAX_PARTICLES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   srs_req_if.sink    req_chan,
   srs_rsp_if.source  rsp_chan
);

   srs_pkg::cmd_type    cmd;
   srs_pkg::status_type status;

   assign req_chan.ready = cmd.take;

   srs_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   srs_datapath #(
      .MAX_PARTICLES (MAX_PARTICLES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_valid           (req_chan.valid),
      .req_weight          (req_chan.weight),
      .req_is_last         (req_chan.is_last),
      .req_offset_fraction (req_chan.offset_fraction),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_chan.valid),
      .rsp_survivor_index  (rsp_chan.survivor_index),
      .rsp_last_index      (rsp_chan.last_index),
      .rsp_total_zero      (rsp_chan.total_zero)
   );

   // An index is never loaded over one the receiver has not yet taken.
   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("index loaded while output register still occupied");

   // Loading and emission never overlap.
   a_no_load_while_emitting: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !cmd.emit)
      else $error("input open while indices are being emitted");

   // The input reopens only after the final index of a run has been emitted.
   a_reopen_after_run: assert property (@(posedge clock) disable iff (reset)
      $rose(req_chan.ready) |-> $past(cmd.finish))
      else $error("input reopened before the run finished");

endmodule

`default_nettype wire

FILE: dv/srs_checker.sv
// Scoreboard for the systematic resampler: watches both channels, predicts the survivor indices
// of each particle set and compares them with what the block sends.
// Depends on srs_pkg, srs_req_if and srs_rsp_if.
`timescale 1ns / 100ps

module srs_checker #(
   parameter int MAX_PARTICLES = srs_pkg::MAX_PARTICLES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   srs_req_if         req_mon,
   srs_rsp_if         rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned pending_count,
   output int unsigned checked_count
);
   import srs_pkg::*;

   typedef struct packed {
      logic [INDEX_W-1:0] survivor_index;
      logic               last_index;
      logic               total_zero;
   } survivor_type;

   // Shadow copy of the particle set being loaded.
   logic [WEIGHT_W-1:0] particle_weight [MAX_PARTICLES];
   int unsigned         particles_held = 0;
   logic [TOTAL_W-1:0]  weight_sum = '0;

   survivor_type survivor_q [$];
   int unsigned  errors = 0;
   int unsigned  checked = 0;

   // Takes one weight item and, when it closes the set, queues the indices it yields.
   task automatic predict_survivors(input logic [WEIGHT_W-1:0] w, input logic closes,
                                    input logic [OFFSET_W-1:0] frac);
      longint unsigned n;
      longint unsigned cum;
      longint unsigned slot;
      longint unsigned scaled_cum;
      int unsigned     p;
      survivor_type    s;
      // A weight arriving on a full store is dropped, but may still close the set.
      if (particles_held < MAX_PARTICLES) begin
         particle_weight[particles_held] = w;
         particles_held++;
         weight_sum = weight_sum + w;
      end
      if (closes) begin
         n = particles_held;
         if (weight_sum == '0) begin
            // Zero total: the identity sequence.
            for (p = 0; p < n; p++) begin
               s.survivor_index = p[INDEX_W-1:0];
               s.last_index     = (p + 1 == n);
               s.total_zero     = 1'b1;
               survivor_q.push_back(s);
            end
         end else begin
            // Cross-multiplied threshold compare, so no division by the total is needed.
            cum  = 0;
            slot = 0;
            for (p = 0; p < n && slot < n; p++) begin
               cum += particle_weight[p];
               scaled_cum = (cum * n) << FRAC_W;
               while (slot < n && scaled_cum > ((slot << FRAC_W) + frac) * weight_sum) begin
                  s.survivor_index = p[INDEX_W-1:0];
                  s.last_index     = (slot + 1 == n);
                  s.total_zero     = 1'b0;
                  survivor_q.push_back(s);
                  slot++;
               end
            end
         end
         particles_held = 0;
         weight_sum     = '0;
      end
   endtask

   // Sample both channels on every edge and compare each result item in order.
   always @(posedge clock) begin
      survivor_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            predict_survivors(req_mon.weight, req_mon.is_last, req_mon.offset_fraction);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            checked++;
            if (survivor_q.size() == 0) begin
               $error("unexpected result item: survivor_index %0d", rsp_mon.survivor_index);
               errors++;
            end else begin
               want = survivor_q.pop_front();
               if (rsp_mon.survivor_index !== want.survivor_index) begin
                  $error("survivor_index: expected %0d, got %0d", want.survivor_index,
                         rsp_mon.survivor_index);
                  errors++;
               end
               if (rsp_mon.last_index !== want.last_index) begin
                  $error("last_index: expected %0d, got %0d", want.last_index,
                         rsp_mon.last_index);
                  errors++;
               end
               if (rsp_mon.total_zero !== want.total_zero) begin
                  $error("total_zero: expected %0d, got %0d", want.total_zero,
                         rsp_mon.total_zero);
                  errors++;
               end
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= survivor_q.size();
      checked_count  <= checked;
   end

endmodule

FILE: dv/tb_systematic_resampler.sv
// Top level of the resampler testbench: clock, reset, weight stimulus, result back-pressure
// and the verdict. Depends on srs_pkg, both channel interfaces, srs_checker and the block.
`timescale 1ns / 100ps

module tb_systematic_resampler;
   import srs_pkg::*;

   localparam int N_MAX          = MAX_PARTICLES_DEF;
   localparam int RANDOM_WEIGHTS = 14;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 200;

   typedef enum {
      SET_MIXED,
      SET_ZERO,
      SET_TAIL_HEAVY
   } set_style_type;

   logic clock = 1'b0;
   logic reset;

   srs_req_if req_chan ();
   srs_rsp_if rsp_chan ();

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned checked_count;

   int unsigned cycle_count = 0;
   int unsigned weights_sent = 0;
   int unsigned sets_sent = 0;
   int unsigned dropped_weights = 0;
   int unsigned set_fill = 0;
   bit          src_burst = 1'b0;

   // Receiver state; only the back-pressure process writes these, bar the request count.
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int unsigned sink_wait = 0;
   int unsigned hold_left = 0;
   bit          sink_burst = 1'b0;

   always #1 clock = ~clock;

   systematic_resampler #(
      .MAX_PARTICLES (N_MAX)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   srs_checker #(
      .MAX_PARTICLES (N_MAX)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL systematic_resampler");
         $finish;
      end
   end

   // Result back-pressure: a random wait after each item, bursts without waits, and long holds.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if ($urandom_range(0, 15) == 0) sink_burst = !sink_burst;
            sink_wait = sink_burst ? 0 : $urandom_range(0, 13);
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (sink_wait != 0) begin
            sink_wait--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return WEIGHT_W'($urandom_range(0, 15));
         3:       return WEIGHT_W'(1) << $urandom_range(0, WEIGHT_W - 1);
         default: return WEIGHT_W'($urandom);
      endcase
   endfunction

   function automatic logic [OFFSET_W-1:0] pick_offset();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return OFFSET_W'($urandom);
      endcase
   endfunction

   // Offers one weight item after a random gap, or none in a burst, and waits until the block takes it.
   task automatic send_weight(input logic [WEIGHT_W-1:0] w, input logic closes,
                              input logic [OFFSET_W-1:0] frac);
      int unsigned gap;
      gap = src_burst ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.weight          <= w;
      req_chan.is_last         <= closes;
      req_chan.offset_fraction <= frac;
      req_chan.valid           <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      weights_sent++;
      if (set_fill >= N_MAX) dropped_weights++;
      set_fill++;
      if (closes) begin
         set_fill = 0;
         sets_sent++;
      end
   endtask

   // Sends a whole particle set; the offset on non-closing items is noise.
   task automatic send_set(input int unsigned count, input set_style_type style,
                           input bit no_gaps);
      int unsigned         i;
      logic [WEIGHT_W-1:0] w;
      src_burst = no_gaps || ($urandom_range(0, 3) == 0);
      for (i = 0; i < count; i++) begin
         case (style)
            SET_ZERO:       w = '0;
            SET_TAIL_HEAVY: w = (i + 1 == count) ? '1 : WEIGHT_W'($urandom_range(0, 255));
            default:        w = pick_weight();
         endcase
         send_weight(w, i + 1 == count, (i + 1 == count) ? pick_offset() : OFFSET_W'($urandom));
      end
   endtask

   // Stops offering items until every predicted index has come back.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      int unsigned   random_sent;
      int unsigned   set_no;
      int unsigned   count;
      set_style_type style;
      reset                    <= 1'b1;
      req_chan.valid           <= 1'b0;
      req_chan.weight          <= '0;
      req_chan.is_last         <= 1'b0;
      req_chan.offset_fraction <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed sets: single particles, zero totals, full-scale weights, extreme offsets.
      send_weight(16'h0000, 1'b1, 16'h0000);
      send_weight(16'hFFFF, 1'b1, 16'hFFFF);
      send_weight(16'h0000, 1'b0, 16'hFFFF);
      send_weight(16'h0000, 1'b0, 16'h0000);
      send_weight(16'h0000, 1'b0, 16'hFFFF);
      send_weight(16'h0000, 1'b1, 16'h8000);
      send_weight(16'hFFFF, 1'b0, 16'h0000);
      send_weight(16'hFFFF, 1'b0, 16'hFFFF);
      send_weight(16'hFFFF, 1'b0, 16'h0000);
      send_weight(16'hFFFF, 1'b1, 16'h0000);
      send_weight(16'h0000, 1'b0, 16'h0000);
      send_weight(16'h0000, 1'b0, 16'h0000);
      send_weight(16'h0001, 1'b1, 16'hFFFF);
      send_weight(16'h0001, 1'b0, 16'h1234);
      send_weight(16'h0000, 1'b0, 16'h0000);
      send_weight(16'hFFFF, 1'b0, 16'h0000);
      send_weight(16'h0000, 1'b0, 16'h0000);
      send_weight(16'h0002, 1'b1, 16'h8000);
      send_weight(16'h1234, 1'b0, 16'h0000);
      send_weight(16'h0000, 1'b1, 16'h0001);
      wait_drained();

      // Long receiver hold while back-to-back sets keep the input busy.
      hold_requests <= hold_requests + 1;
      send_set(4, SET_MIXED, 1'b1);
      send_set(5, SET_MIXED, 1'b1);
      wait_drained();

      // An overfull store whose heavy closing weight is dropped, then small random sets.
      random_sent = 0;
      set_no      = 0;
      while (random_sent < RANDOM_WEIGHTS) begin
         set_no++;
         if (set_no == 1) begin
            send_set(N_MAX + 3, SET_TAIL_HEAVY, 1'b0);
         end else begin
            count = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            style = ($urandom_range(0, 7) == 0) ? SET_ZERO : SET_MIXED;
            send_set(count, style, 1'b0);
            random_sent += count;
         end
         if ($urandom_range(0, 5) == 0) wait_drained();
      end

      // Let the last set drain, then watch for stray items before the verdict.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Resampled %0d particle sets from %0d weights, %0d dropped on a full store.",
               sets_sent, weights_sent, dropped_weights);
      $display("Checked %0d survivor indices, %0d mismatches.", checked_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASS systematic_resampler");
      end else begin
         $display("FAIL systematic_resampler");
      end
      $finish;
   end

endmodule
